### src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> b holds in the same cycle
`define AST_SAME(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: label");

// a holds -> b holds in the next cycle
`define AST_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

### src/fvsm_pkg.sv
// Package: constants, types and sine table for the five voice tone mixer
package fvsm_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int NOTE_SAMPLES    = 44100;

    localparam int VOICES     = 5;
    localparam int STEP_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int QUARTER    = 1 << (TABLE_ADDR_BITS - 2);
    localparam int Q_BITS     = TABLE_ADDR_BITS - 2;
    localparam int SUM_BITS   = SAMPLE_BITS + 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_MAX_U   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    localparam logic signed [SAMPLE_BITS-1:0] AMP_MAX =
        SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SAMPLE_BITS-1:0] AMP_MIN = -AMP_MAX - SAMPLE_BITS'(1);
    localparam logic signed [15:0] FIFTH_Q16 = 16'sd13107;
    localparam logic [COUNT_BITS-1:0] NOTE_LAST = COUNT_BITS'(NOTE_SAMPLES - 1);

    // configuration register indexes
    localparam logic [2:0] REG_VOICE_MODE     = 3'd0;
    localparam logic [2:0] REG_TONE_STEP_BASE = 3'd1;

    typedef logic [TABLE_ADDR_BITS-1:0] tab_addr_t;
    typedef logic [SAMPLE_BITS-2:0] amp_t;
    typedef logic [QUARTER-1:0][SAMPLE_BITS-2:0] quarter_table_t;

    // per-word control from the phase unit to the pipeline
    typedef struct packed {
        logic [VOICES-1:0][TABLE_ADDR_BITS-1:0] addr;
        logic                                   last;
    } phase_word_t;

    // Q30 Taylor series sine of one quarter-wave point, scaled to the amplitude
    function automatic logic [63:0] quarter_sine(input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (q * HALF_PI_Q30) >> (TABLE_ADDR_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 5; k++)
        begin
            term = (term * x2) >> 30;
            case (k)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if (k % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        r = (sum * AMP_MAX_U + (64'd1 << 29)) >> 30;
        if (r > AMP_MAX_U)
            r = AMP_MAX_U;
        return r;
    endfunction

    function automatic quarter_table_t build_quarter_table();
        quarter_table_t t;
        for (int i = 0; i < QUARTER; i++)
            t[i] = amp_t'(quarter_sine(64'(i)));
        return t;
    endfunction

    localparam quarter_table_t QUARTER_TABLE = build_quarter_table();
    // the quarter-wave peak sits one past the table's end
    localparam amp_t QUARTER_PEAK = amp_t'(quarter_sine(64'(QUARTER)));

endpackage

### src/fvsm_phase.sv
// Phase accumulators, tuning words and note counter
module fvsm_phase (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_addr,
    input  logic [fvsm_pkg::STEP_BITS-1:0] cfg_wdata,
    input  logic                        advance,
    input  logic                        restart,
    output fvsm_pkg::phase_word_t       word
);
    import fvsm_pkg::*;

    logic [VOICES-1:0][PHASE_BITS-1:0] step_reg;
    logic [VOICES-1:0][PHASE_BITS-1:0] phase_reg;
    logic [VOICES-1:0][PHASE_BITS-1:0] phase_cur;
    logic [VOICES-1:0][PHASE_BITS-1:0] phase_next;
    logic [COUNT_BITS-1:0]             count_reg;
    logic [COUNT_BITS-1:0]             count_cur;
    logic [COUNT_BITS-1:0]             count_next;
    logic                              last;

    always_comb
    begin
        count_cur = restart ? '0 : count_reg;
        last      = (count_cur >= NOTE_LAST);
        count_next = last ? '0 : count_cur + COUNT_BITS'(1);
        for (int i = 0; i < VOICES; i++)
        begin
            phase_cur[i]  = restart ? '0 : phase_reg[i];
            phase_next[i] = last ? '0 : phase_cur[i] + step_reg[i];
            word.addr[i]  = phase_cur[i][PHASE_BITS-1 -: TABLE_ADDR_BITS];
        end
        word.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (cfg_addr == REG_TONE_STEP_BASE + 3'(i))
                    step_reg[i] <= cfg_wdata[PHASE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/fvsm_sine.sv
// Sine lookup of one table address through the quarter-wave table
module fvsm_sine (
    input  fvsm_pkg::tab_addr_t                   addr,
    output logic signed [fvsm_pkg::SAMPLE_BITS-1:0] value
);
    import fvsm_pkg::*;

    logic [1:0]        quad;
    logic [Q_BITS-1:0] q;
    amp_t              mag;

    always_comb
    begin
        quad = addr[TABLE_ADDR_BITS-1 -: 2];
        q    = addr[Q_BITS-1:0];
        if (!quad[0])
            mag = QUARTER_TABLE[q];
        else if (q == '0)
            mag = QUARTER_PEAK;
        else
            mag = QUARTER_TABLE[Q_BITS'(-q)];   // QUARTER - q
        if (quad[1])
            value = -$signed({1'b0, mag});
        else
            value = $signed({1'b0, mag});
    end

endmodule

### src/fvsm_mix.sv
// Five-voice average with saturation in mode 1, voice 0 passed through in mode 0, and Q1.15 conversion
module fvsm_mix (
    input  logic                                  mode,
    input  logic signed [fvsm_pkg::SUM_BITS-1:0]  mix_in,
    output logic signed [fvsm_pkg::OUT_BITS-1:0]  sample
);
    import fvsm_pkg::*;

    localparam int PROD_BITS = SUM_BITS + 16;

    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   rounded;
    logic signed [SUM_BITS-1:0]    avg;
    logic signed [SAMPLE_BITS-1:0] v;

    always_comb
    begin
        prod    = PROD_BITS'(mix_in) * PROD_BITS'(FIFTH_Q16);
        rounded = (prod + PROD_BITS'(32768)) >>> 16;
        avg     = SUM_BITS'(rounded);
        if (!mode)
            v = SAMPLE_BITS'(mix_in);
        else if (avg > SUM_BITS'(AMP_MAX))
            v = AMP_MAX;
        else if (avg < SUM_BITS'(AMP_MIN))
            v = AMP_MIN;
        else
            v = SAMPLE_BITS'(avg);
    end

    generate
        if (SAMPLE_BITS > OUT_BITS)
        begin : g_narrow
            assign sample = OUT_BITS'(v >>> (SAMPLE_BITS - OUT_BITS));
        end
        else if (SAMPLE_BITS < OUT_BITS)
        begin : g_widen
            assign sample = {v, {(OUT_BITS - SAMPLE_BITS){1'b0}}};
        end
        else
        begin : g_same
            assign sample = OUT_BITS'(v);
        end
    endgenerate

endmodule

### src/five_voice_sine_tone_mixer_unit.sv
// Five voice sine tone mixer: top level with the three-stage word pipeline
// An accepted word passes the stage A, stage B and output registers on its way to m_tdata.
// Throughput: one word per cycle unless m_tready stalls the output; phase update,
// table lookup and mix are separate stages, each one register deep.
// Reset (rst_n low, asynchronous): phases, note counter, tuning words and mode
// clear to zero and the pipeline empties.
module five_voice_sine_tone_mixer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample_value
    output logic        m_tlast     // note_end
);
    import fvsm_pkg::*;

    logic        mode_reg;
    logic        accept;
    logic        ready_b;
    logic        ready_c;
    phase_word_t phase_word;

    logic        a_valid_reg;
    phase_word_t a_word_reg;
    logic        a_mode_reg;

    logic                          b_valid_reg;
    logic                          b_mode_reg;
    logic                          b_last_reg;
    logic signed [SUM_BITS-1:0]    b_mix_reg;
    logic signed [SUM_BITS-1:0]    b_mix_next;
    logic [VOICES-1:0][SAMPLE_BITS-1:0] voice_val;

    logic signed [OUT_BITS-1:0] sample;
    logic                       out_valid_reg;
    logic [OUT_BITS-1:0]        out_data_reg;
    logic                       out_last_reg;

    assign ready_c  = !out_valid_reg || m_tready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign s_tready = !a_valid_reg || ready_b;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we && cfg_addr == REG_VOICE_MODE)
            mode_reg <= cfg_wdata[0];
    end

    fvsm_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .restart   (s_tdata[0]),
        .word      (phase_word)
    );

    // stage A: table addresses of the current phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (s_tready)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_word_reg <= phase_word;
            a_mode_reg <= mode_reg;
        end
    end

    // stage B: five lookups, summed in five-voice mode
    generate
        for (genvar i = 0; i < VOICES; i++)
        begin : g_voice
            fvsm_sine u_sine (
                .addr  (a_word_reg.addr[i]),
                .value (voice_val[i])
            );
        end
    endgenerate

    always_comb
    begin
        if (a_mode_reg)
        begin
            b_mix_next = '0;
            for (int i = 0; i < VOICES; i++)
                b_mix_next = b_mix_next + SUM_BITS'($signed(voice_val[i]));
        end
        else
        begin
            b_mix_next = SUM_BITS'($signed(voice_val[0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (ready_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && a_valid_reg)
        begin
            b_mix_reg  <= b_mix_next;
            b_mode_reg <= a_mode_reg;
            b_last_reg <= a_word_reg.last;
        end
    end

    // stage C: average and saturate in five-voice mode, convert
    fvsm_mix u_mix (
        .mode   (b_mode_reg),
        .mix_in (b_mix_reg),
        .sample (sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready_c)
            out_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && b_valid_reg)
        begin
            out_data_reg <= sample;
            out_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### src/fvsm_checker.sv
// Port-level checks for the five voice tone mixer, bound to the top level
`include "assert_macros.svh"

module fvsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled output word stays put
    `AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // handshake lines are never unknown out of reset
    `AST_SAME(a_handshake_known, 1'b1, !$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
    // an empty output stage never blocks the input
    `AST_SAME(a_ready_when_empty, !m_tvalid, s_tready)
    // a draining sink keeps the whole pipeline moving
    `AST_SAME(a_ready_when_drain, m_tready, s_tready)

endmodule

bind five_voice_sine_tone_mixer_unit fvsm_checker u_fvsm_checker (.*);

### tb/sv/five_voice_sine_tone_mixer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the five voice sine tone mixer: predicts each sample and checks the stream
module five_voice_sine_tone_mixer_unit_tb;
    import fvsm_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ROUNDS = 6;
    localparam int ROUND_WORDS   = 220;
    localparam int SINK_SLOTS    = 13;

    localparam longint unsigned TICK_RATE = 88200;
    localparam longint FIFTH_SCALE = 13107;
    localparam longint ROUND_HALF  = 64'sd1 << 15;
    localparam longint Q15_MAX     = 32767;
    localparam longint Q15_MIN     = -32768;

    // indexes past the last tuning word: writes there are dropped
    localparam logic [2:0] REG_SPARE_FIRST = REG_TONE_STEP_BASE + 3'(VOICES);
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               note_end;
    } tone_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [15:0] sample_value
    logic        m_tlast;    // note_end

    // predictor state
    int                    sine_quarter [0:QUARTER];
    logic [PHASE_BITS-1:0] phase_acc [VOICES];
    logic [31:0]           step_word [VOICES];
    logic                  mix_all;
    int unsigned           note_count;

    tone_word_t pending_words [$];

    // stimulus shaping
    bit          sender_gaps;
    bit          sink_stalls;
    int          burst_left;
    logic [SINK_SLOTS-1:0] sink_mask;
    int          sink_slot;

    int          cycle_count;
    int          words_sent;
    int          restarts_sent;
    int          samples_checked;
    int          note_ends_seen;
    int          settings_loaded;
    int          mismatches;

    five_voice_sine_tone_mixer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d samples outstanding", $time, pending_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Q30 Taylor sine of one quarter-wave point, scaled to full amplitude
    function automatic int quarter_amp(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        x    = (64'(q) * HALF_PI_Q30) >> Q_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
                acc = (acc >= term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        r = (acc * AMP_MAX_U + (64'd1 << 29)) >> 30;
        if (r > AMP_MAX_U)
            r = AMP_MAX_U;
        return int'(r);
    endfunction

    function automatic int wave_of(input logic [PHASE_BITS-1:0] phase);
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic [1:0]                 quad;
        int unsigned                qi;
        int                         v;
        addr = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        quad = addr[TABLE_ADDR_BITS-1 -: 2];
        qi   = addr[Q_BITS-1:0];
        // odd quadrants run the quarter wave backwards, upper half is negated
        v = quad[0] ? sine_quarter[QUARTER - qi] : sine_quarter[qi];
        return quad[1] ? -v : v;
    endfunction

    function automatic tone_word_t next_tone_word(input logic restart);
        tone_word_t w;
        longint     acc;
        logic       last;
        if (restart)
        begin
            for (int v = 0; v < VOICES; v++)
                phase_acc[v] = '0;
            note_count = 0;
        end
        if (mix_all)
        begin
            acc = 0;
            for (int v = 0; v < VOICES; v++)
                acc += wave_of(phase_acc[v]);
            acc = (acc * FIFTH_SCALE + ROUND_HALF) >>> 16;
        end
        else
            acc = wave_of(phase_acc[0]);
        if (acc > Q15_MAX)
            acc = Q15_MAX;
        else if (acc < Q15_MIN)
            acc = Q15_MIN;
        last = (note_count >= NOTE_SAMPLES - 1);
        for (int v = 0; v < VOICES; v++)
            phase_acc[v] = last ? '0 : phase_acc[v] + step_word[v][PHASE_BITS-1:0];
        note_count = last ? 0 : (note_count + 1) & 16'hFFFF;
        w.sample   = 16'(acc);
        w.note_end = last;
        return w;
    endfunction

    function automatic logic [31:0] audio_step(input int unsigned freq);
        return 32'((64'(freq) << 32) / TICK_RATE);
    endfunction

    function automatic logic [31:0] random_step();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return audio_step($urandom_range(20, 20000));
        endcase
    endfunction

    // result side: check each accepted word, then drive the stall pattern
    always @(posedge clk)
    begin : sink
        tone_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, got sample %0d note_end %0b",
                         $time, $signed(m_tdata), m_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                samples_checked++;
                if (m_tlast)
                    note_ends_seen++;
                if (m_tdata !== want.sample)
                begin
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, want.sample, $signed(m_tdata));
                    mismatches++;
                end
                if (m_tlast !== want.note_end)
                begin
                    $display("%0t: note_end mismatch, expected %0b, got %0b",
                             $time, want.note_end, m_tlast);
                    mismatches++;
                end
            end
        end
        m_tready <= sink_stalls ? sink_mask[sink_slot] : 1'b1;
        sink_slot = (sink_slot + 1) % SINK_SLOTS;
    end

    task automatic set_idling(input bit gaps, input bit stalls);
        sender_gaps = gaps;
        sink_stalls = stalls;
        burst_left  = 0;
        sink_mask   = '1;
        repeat (3) sink_mask[$urandom_range(0, SINK_SLOTS - 1)] = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_VOICE_MODE)
            mix_all = value[0];
        else if (idx >= REG_TONE_STEP_BASE && idx < REG_SPARE_FIRST)
            step_word[idx - REG_TONE_STEP_BASE] = value;
    endtask

    task automatic load_tones(input logic mode, input logic [VOICES-1:0][31:0] steps);
        logic [31:0] mode_word;
        mode_word    = $urandom;
        mode_word[0] = mode;
        write_reg(REG_VOICE_MODE, mode_word);
        for (int v = 0; v < VOICES; v++)
            write_reg(REG_TONE_STEP_BASE + 3'(v), steps[v]);
        write_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST, $urandom);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // one word per call; bursts of random length, with random gaps between them when sender_gaps is set
    task automatic send_word(input logic restart);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        pending_words.push_back(next_tone_word(restart));
        words_sent++;
        if (restart)
            restarts_sent++;
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // out of reset: mode 0, zero tuning words, so silence
    task automatic test_reset_defaults();
        set_idling(1'b0, 1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        stop_and_drain();
    endtask

    // quarter-turn steps land on zero crossings and both peaks, plus wrapping steps
    task automatic test_quadrant_extremes();
        logic [VOICES-1:0][31:0] steps;
        set_idling(1'b1, 1'b1);
        steps    = '0;
        steps[0] = 32'h4000_0000;
        load_tones(1'b0, steps);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        stop_and_drain();

        steps[1] = 32'h8000_0000;
        steps[2] = 32'hC000_0000;
        steps[3] = 32'hFFFF_FFFF;
        steps[4] = 32'h0000_0000;
        load_tones(1'b1, steps);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        stop_and_drain();

        steps = {VOICES{32'h4000_0000}};
        load_tones(1'b1, steps);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        stop_and_drain();

        // mode flip inside a note leaves the phases running
        write_reg(REG_VOICE_MODE, 32'h0);
        cfg_we <= 1'b0;
        repeat (3) send_word(1'b0);
        stop_and_drain();
    endtask

    task automatic test_random_tones();
        logic [VOICES-1:0][31:0] steps;
        logic                    mode;
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            set_idling(r % 3 != 0, r % 2 != 0);
            for (int v = 0; v < VOICES; v++)
                steps[v] = (r == 0) ? '0 : (r == 1) ? '1 : random_step();
            mode = (r == 0) ? 1'b0 : (r == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            load_tones(mode, steps);
            repeat (ROUND_WORDS) send_word($urandom_range(0, 31) == 0);
            stop_and_drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        mix_all   = 1'b0;
        note_count = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            phase_acc[v] = '0;
            step_word[v] = '0;
        end
        for (int q = 0; q <= QUARTER; q++)
            sine_quarter[q] = quarter_amp(q);
        set_idling(1'b0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_quadrant_extremes();
        test_random_tones();

        $display("covered %0d words (%0d restarts) over %0d tone settings, both mix modes",
                 words_sent, restarts_sent, settings_loaded);
        $display("checked %0d samples, %0d note ends, %0d mismatches",
                 samples_checked, note_ends_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/fvsm_pkg.sv
src/fvsm_phase.sv
src/fvsm_sine.sv
src/fvsm_mix.sv
src/five_voice_sine_tone_mixer_unit.sv
src/fvsm_checker.sv
tb/sv/five_voice_sine_tone_mixer_unit_tb.sv
